// ----- rtl/tpa_pkg.sv -----
package tpa_pkg;

  // Request codes on the input channel
  localparam logic OP_BEGIN  = 1'b0;
  localparam logic OP_VERTEX = 1'b1;

  // Result kinds
  localparam logic KIND_TRIANGLE = 1'b0;
  localparam logic KIND_ERROR    = 1'b1;

  // Number of corners in a triangle, and how many vertices are held before one is emitted
  localparam int unsigned CORNERS    = 3;
  localparam int unsigned HELD_SLOTS = 2;

  typedef enum logic [1:0] {
    MODE_STRIP   = 2'd0,
    MODE_FAN     = 2'd1,
    MODE_LIST    = 2'd2,
    MODE_UNKNOWN = 2'd3
  } mode_t;

  // Control that travels with one result from the assembler to the output buffer
  typedef struct packed {
    logic valid;
    logic kind;
  } res_ctl_t;

endpackage

// ----- rtl/tpa_assembler.sv -----
module tpa_assembler #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          opcode,
  input  logic [1:0]                    prim_mode,
  input  logic signed [COORD_WIDTH-1:0] vert_x,
  input  logic signed [COORD_WIDTH-1:0] vert_y,
  output tpa_pkg::res_ctl_t             res_ctl,
  output logic [6*COORD_WIDTH-1:0]      res_data
);

  tpa_pkg::mode_t                current_mode_r, current_mode_nxt;
  logic [1:0]                    vertex_count_r, vertex_count_nxt;
  logic signed [COORD_WIDTH-1:0] first_x_r, first_y_r, second_x_r, second_y_r;
  logic signed [COORD_WIDTH-1:0] first_x_nxt, first_y_nxt, second_x_nxt, second_y_nxt;
  logic                          count_full;

  assign count_full = (vertex_count_r == 2'(tpa_pkg::HELD_SLOTS));

  always_comb begin
    current_mode_nxt = current_mode_r;
    vertex_count_nxt = vertex_count_r;
    first_x_nxt      = first_x_r;
    first_y_nxt      = first_y_r;
    second_x_nxt     = second_x_r;
    second_y_nxt     = second_y_r;
    res_ctl.valid    = 1'b0;
    res_ctl.kind     = tpa_pkg::KIND_TRIANGLE;
    res_data         = {first_x_r, first_y_r, second_x_r, second_y_r, vert_x, vert_y};
    if (accept) begin
      if (opcode == tpa_pkg::OP_BEGIN) begin
        current_mode_nxt = tpa_pkg::mode_t'(prim_mode);
        vertex_count_nxt = '0;
      end else if (current_mode_r == tpa_pkg::MODE_UNKNOWN) begin
        res_ctl.valid = 1'b1;
        res_ctl.kind  = tpa_pkg::KIND_ERROR;
        res_data      = '0;
      end else if (!count_full) begin
        // stash into slot given by the count
        if (vertex_count_r == 2'd0) begin
          first_x_nxt = vert_x;
          first_y_nxt = vert_y;
        end else begin
          second_x_nxt = vert_x;
          second_y_nxt = vert_y;
        end
        vertex_count_nxt = vertex_count_r + 2'd1;
      end else begin
        res_ctl.valid = 1'b1;
        unique case (current_mode_r)
          tpa_pkg::MODE_STRIP: begin
            first_x_nxt  = second_x_r;
            first_y_nxt  = second_y_r;
            second_x_nxt = vert_x;
            second_y_nxt = vert_y;
          end
          tpa_pkg::MODE_FAN: begin
            second_x_nxt = vert_x;
            second_y_nxt = vert_y;
          end
          default: begin
            vertex_count_nxt = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_mode_r <= tpa_pkg::MODE_UNKNOWN;
      vertex_count_r <= '0;
    end else begin
      current_mode_r <= current_mode_nxt;
      vertex_count_r <= vertex_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_x_r  <= first_x_nxt;
    first_y_r  <= first_y_nxt;
    second_x_r <= second_x_nxt;
    second_y_r <= second_y_nxt;
  end

endmodule

// ----- rtl/tpa_out_buf.sv -----
module tpa_out_buf #(
  parameter int DATA_WIDTH = 192
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tpa_pkg::res_ctl_t     res_ctl,
  input  logic [DATA_WIDTH-1:0] res_data,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_kind,
  output logic [DATA_WIDTH-1:0] out_data
);

  logic                  out_valid_r, skid_valid_r;
  logic                  out_kind_r, skid_kind_r;
  logic [DATA_WIDTH-1:0] out_data_r, skid_data_r;
  logic                  out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (out_free && skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else if (out_free) begin
        out_valid_r <= res_ctl.valid;
      end else if (res_ctl.valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (out_free && skid_valid_r) begin
      out_kind_r <= skid_kind_r;
      out_data_r <= skid_data_r;
    end else if (out_free) begin
      out_kind_r <= res_ctl.kind;
      out_data_r <= res_data;
    end else if (res_ctl.valid) begin
      skid_kind_r <= res_ctl.kind;
      skid_data_r <= res_data;
    end
  end

endmodule

// ----- rtl/triangle_primitive_assembly.sv -----
// Triangle primitive assembly: a begin request (opcode 0) selects strip, fan,
// list or unknown mode and clears the vertex count; each vertex request
// (opcode 1) is folded into the held pair and, once two vertices are held,
// yields one triangle (held first, held second, new vertex). A vertex under
// the unknown mode yields an error result with every corner zero. Rate: one
// request per clock while in_stall is low. A result goes into the output
// register at its accepting edge, or the skid register if the output stalls.
// The held vertices update at the accepting edge, so back-to-back vertices
// never wait on each other. The output register is backed by a one-entry skid
// register. in_stall rises only when both hold a result that the downstream
// side has not taken. It drops at the edge that takes the output register, so
// a stalled result channel holds the input off for as long as it stays
// stalled. Reset leaves the mode unknown.
module triangle_primitive_assembly #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [1:0]                    in_prim_mode,
  input  logic signed [COORD_WIDTH-1:0] in_vert_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_result_kind,
  output logic signed [COORD_WIDTH-1:0] out_corner_a_x,
  output logic signed [COORD_WIDTH-1:0] out_corner_a_y,
  output logic signed [COORD_WIDTH-1:0] out_corner_b_x,
  output logic signed [COORD_WIDTH-1:0] out_corner_b_y,
  output logic signed [COORD_WIDTH-1:0] out_corner_c_x,
  output logic signed [COORD_WIDTH-1:0] out_corner_c_y
);

  localparam int DATA_WIDTH = 2 * tpa_pkg::CORNERS * COORD_WIDTH;

  tpa_pkg::res_ctl_t     res_ctl;
  logic [DATA_WIDTH-1:0] res_data;
  logic [DATA_WIDTH-1:0] out_data;
  logic                  buf_full;
  logic                  accept;

  // Hold off new requests only while the skid register is occupied
  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  tpa_assembler #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_assembler (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .opcode    (in_opcode),
    .prim_mode (in_prim_mode),
    .vert_x    (in_vert_x),
    .vert_y    (in_vert_y),
    .res_ctl   (res_ctl),
    .res_data  (res_data)
  );

  tpa_out_buf #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_ctl   (res_ctl),
    .res_data  (res_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_result_kind),
    .out_data  (out_data)
  );

  // Unpack corners: a, b, c from the top down, x above y
  assign {out_corner_a_x, out_corner_a_y,
          out_corner_b_x, out_corner_b_y,
          out_corner_c_x, out_corner_c_y} = out_data;

endmodule

// ----- rtl/tpa_checker.sv -----
module tpa_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_opcode,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_result_kind,
  input logic signed [COORD_WIDTH-1:0] out_corner_a_x,
  input logic signed [COORD_WIDTH-1:0] out_corner_a_y,
  input logic signed [COORD_WIDTH-1:0] out_corner_b_x,
  input logic signed [COORD_WIDTH-1:0] out_corner_b_y,
  input logic signed [COORD_WIDTH-1:0] out_corner_c_x,
  input logic signed [COORD_WIDTH-1:0] out_corner_c_y
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_corner_a_x) && $stable(out_corner_b_y)
      && $stable(out_corner_c_x) && $stable(out_result_kind))
    else $error("stalled result changed");

  // Error results carry zero corners
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == tpa_pkg::KIND_ERROR |->
      out_corner_a_x == '0 && out_corner_a_y == '0 && out_corner_b_x == '0
      && out_corner_b_y == '0 && out_corner_c_x == '0 && out_corner_c_y == '0)
    else $error("error result with non-zero corner");

  // A begin request into an empty buffer gives no result
  a_begin_silent: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && !in_stall && in_opcode == tpa_pkg::OP_BEGIN |=> !out_valid)
    else $error("begin request produced a result");

endmodule

bind triangle_primitive_assembly tpa_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tpa_checker (.*);

// ----- bench/triangle_checker.sv -----
`timescale 1ns / 100ps

module triangle_checker #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                in_opcode,
  input  logic [1:0]          in_prim_mode,
  input  logic signed [W-1:0] in_vert_x,
  input  logic signed [W-1:0] in_vert_y,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                out_result_kind,
  input  logic signed [W-1:0] out_corner_a_x,
  input  logic signed [W-1:0] out_corner_a_y,
  input  logic signed [W-1:0] out_corner_b_x,
  input  logic signed [W-1:0] out_corner_b_y,
  input  logic signed [W-1:0] out_corner_c_x,
  input  logic signed [W-1:0] out_corner_c_y,
  output int                  mismatches,
  output int                  backlog
);

  typedef struct {
    logic                kind;
    logic signed [W-1:0] ax, ay, bx, by, cx, cy;
  } triangle_t;

  triangle_t expected_tris[$];

  // Own copy of the assembler state
  tpa_pkg::mode_t      asm_mode;
  logic [1:0]          held_count;
  logic signed [W-1:0] first_x, first_y, second_x, second_y;

  // Fold one vertex into the held pair; return 1 when it yields a result.
  function automatic bit fold_vertex(input logic signed [W-1:0] vx, vy,
                                     output triangle_t t);
    t = '{default: '0};
    if (asm_mode == tpa_pkg::MODE_UNKNOWN) begin
      t.kind = tpa_pkg::KIND_ERROR;
      return 1'b1;
    end
    if (held_count < tpa_pkg::HELD_SLOTS) begin
      if (held_count == 2'd0) begin
        first_x = vx;
        first_y = vy;
      end else begin
        second_x = vx;
        second_y = vy;
      end
      held_count++;
      return 1'b0;
    end
    t.kind = tpa_pkg::KIND_TRIANGLE;
    t.ax = first_x;
    t.ay = first_y;
    t.bx = second_x;
    t.by = second_y;
    t.cx = vx;
    t.cy = vy;
    if (asm_mode == tpa_pkg::MODE_LIST) begin
      held_count = 2'd0;
    end else begin
      // strip slides the pair along, fan keeps its hub vertex
      if (asm_mode == tpa_pkg::MODE_STRIP) begin
        first_x = second_x;
        first_y = second_y;
      end
      second_x = vx;
      second_y = vy;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(input string name,
                                      input logic signed [W-1:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    triangle_t want;
    triangle_t fresh;
    if (!rst_n) begin
      asm_mode   = tpa_pkg::MODE_UNKNOWN;
      held_count = 2'd0;
      mismatches = 0;
      expected_tris.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tris.size() == 0) begin
          $error("unexpected result: kind %0d", out_result_kind);
          mismatches++;
        end else begin
          want = expected_tris.pop_front();
          check_field("result_kind", want.kind, out_result_kind);
          check_field("corner_a_x", want.ax, out_corner_a_x);
          check_field("corner_a_y", want.ay, out_corner_a_y);
          check_field("corner_b_x", want.bx, out_corner_b_x);
          check_field("corner_b_y", want.by, out_corner_b_y);
          check_field("corner_c_x", want.cx, out_corner_c_x);
          check_field("corner_c_y", want.cy, out_corner_c_y);
        end
      end
      if (in_valid && !in_stall) begin
        if (in_opcode == tpa_pkg::OP_BEGIN) begin
          asm_mode   = tpa_pkg::mode_t'(in_prim_mode);
          held_count = 2'd0;
        end else if (fold_vertex(in_vert_x, in_vert_y, fresh)) begin
          expected_tris.push_back(fresh);
        end
      end
    end
    backlog <= expected_tris.size();
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int W              = 32;
  localparam int TOTAL_REQUESTS = 700;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int LONG_HOLD      = 150;
  localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_opcode    = tpa_pkg::OP_BEGIN;
  logic [1:0]          in_prim_mode = tpa_pkg::MODE_UNKNOWN;
  logic signed [W-1:0] in_vert_x    = '0;
  logic signed [W-1:0] in_vert_y    = '0;
  logic                out_stall    = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic                out_result_kind;
  logic signed [W-1:0] out_corner_a_x, out_corner_a_y;
  logic signed [W-1:0] out_corner_b_x, out_corner_b_y;
  logic signed [W-1:0] out_corner_c_x, out_corner_c_y;

  int mismatches;
  int backlog;
  int sent   = 0;
  int cycles = 0;
  bit brisk  = 1'b0;   // when set, the sender offers back to back

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  triangle_primitive_assembly #(.COORD_WIDTH(W)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_prim_mode    (in_prim_mode),
    .in_vert_x       (in_vert_x),
    .in_vert_y       (in_vert_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_corner_a_x  (out_corner_a_x),
    .out_corner_a_y  (out_corner_a_y),
    .out_corner_b_x  (out_corner_b_x),
    .out_corner_b_y  (out_corner_b_y),
    .out_corner_c_x  (out_corner_c_x),
    .out_corner_c_y  (out_corner_c_y)
  );

  triangle_checker #(.W(W)) tri_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_prim_mode    (in_prim_mode),
    .in_vert_x       (in_vert_x),
    .in_vert_y       (in_vert_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_corner_a_x  (out_corner_a_x),
    .out_corner_a_y  (out_corner_a_y),
    .out_corner_b_x  (out_corner_b_x),
    .out_corner_b_y  (out_corner_b_y),
    .out_corner_c_x  (out_corner_c_x),
    .out_corner_c_y  (out_corner_c_y),
    .mismatches      (mismatches),
    .backlog         (backlog)
  );

  // Drop the run if it hangs anywhere.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one request after a random gap, then hold it until accepted.
  // Valid stays high across back-to-back requests: only one assignment per edge.
  task automatic send_request(input logic op, input tpa_pkg::mode_t mode,
                              input logic signed [W-1:0] x, y);
    int gap;
    gap = brisk ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_prim_mode <= mode;
    in_vert_x    <= x;
    in_vert_y    <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Begin request: vertex fields are ignored, so fill them with noise.
  task automatic begin_prim(input tpa_pkg::mode_t mode);
    send_request(tpa_pkg::OP_BEGIN, mode, $urandom, $urandom);
  endtask

  // Vertex request: the mode field is ignored, so fill it with noise.
  task automatic put_vertex(input logic signed [W-1:0] x, y);
    send_request(tpa_pkg::OP_VERTEX, tpa_pkg::mode_t'($urandom_range(0, 3)), x, y);
  endtask

  // Bias coordinates towards the extremes now and then.
  function automatic logic signed [W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Result side: stall for a random number of cycles before each result,
  // with calm stretches and one long hold-off to back the block up.
  initial begin
    int  hold;
    int  taken;
    bit  quick;
    bit  pressed;
    hold    = 0;
    taken   = 0;
    quick   = 1'b0;
    pressed = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (taken % 16 == 0) quick = ($urandom_range(0, 3) == 0);
      if (!pressed && taken == 60) begin
        // hold off long enough for the skid buffer to fill and in_stall to rise
        hold    = LONG_HOLD;
        pressed = 1'b1;
      end else begin
        hold = quick ? 0 : $urandom_range(0, 7);
      end
    end
  end

  // Request side and verdict.
  initial begin
    tpa_pkg::mode_t m;
    int             n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Vertex straight out of reset: mode is unknown, so expect an error result.
    put_vertex(COORD_MAX, COORD_MIN);

    // Strip with extreme coordinates; the pair slides along on each triangle.
    begin_prim(tpa_pkg::MODE_STRIP);
    put_vertex(COORD_MAX, COORD_MAX);
    put_vertex(COORD_MIN, COORD_MIN);
    put_vertex('0, '1);
    put_vertex('1, '0);
    put_vertex(1, COORD_MAX);

    // Fan: the hub vertex stays put.
    begin_prim(tpa_pkg::MODE_FAN);
    put_vertex(COORD_MIN, COORD_MAX);
    put_vertex(7, -7);
    put_vertex(COORD_MAX, '0);
    put_vertex('1, COORD_MIN);

    // List: two independent triangles.
    begin_prim(tpa_pkg::MODE_LIST);
    put_vertex(COORD_MAX, COORD_MIN);
    put_vertex(COORD_MIN, COORD_MAX);
    put_vertex('0, '0);
    put_vertex('1, '1);
    put_vertex(123456, -654321);
    put_vertex(COORD_MAX, COORD_MAX);

    // Begin part-way through a strip: the count must clear.
    begin_prim(tpa_pkg::MODE_STRIP);
    put_vertex(11, 12);
    begin_prim(tpa_pkg::MODE_LIST);
    put_vertex(21, 22);
    put_vertex(31, 32);
    put_vertex(41, 42);

    // Explicit unknown mode.
    begin_prim(tpa_pkg::MODE_UNKNOWN);
    put_vertex(COORD_MIN, '1);

    // Random primitives: mostly well-formed runs with random content,
    // some stray vertices that carry on the previous mode.
    while (sent < TOTAL_REQUESTS) begin
      brisk = ($urandom_range(0, 3) == 0);
      n     = $urandom_range(0, 10);
      case ($urandom_range(0, 9))
        0, 1, 2: m = tpa_pkg::MODE_STRIP;
        3, 4, 5: m = tpa_pkg::MODE_FAN;
        6, 7, 8: m = tpa_pkg::MODE_LIST;
        default: m = tpa_pkg::MODE_UNKNOWN;
      endcase
      if ($urandom_range(0, 9) != 0) begin_prim(m);
      repeat (n) put_vertex(pick_coord(), pick_coord());
    end
    in_valid <= 1'b0;

    // Drain: let every outstanding triangle arrive, then watch for strays.
    @(posedge clk);
    wait (backlog == 0);
    repeat (24) @(posedge clk);
    if (mismatches == 0 && backlog == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- triangle_primitive_assembly.f -----
rtl/tpa_pkg.sv
rtl/tpa_assembler.sv
rtl/tpa_out_buf.sv
rtl/triangle_primitive_assembly.sv
rtl/tpa_checker.sv
bench/triangle_checker.sv
bench/tb.sv
